>>> hw/rtl/pisc_pkg.sv
package pisc_pkg;

  // Field and datapath widths
  localparam int SPEED_W  = 16;
  localparam int ERR_W    = SPEED_W + 1;
  localparam int GAIN_W   = 32;
  localparam int LIMIT_W  = 15;
  localparam int ACC_W    = 32;
  localparam int PROD_W   = GAIN_W + 1 + ERR_W;
  localparam int SUM_W    = PROD_W + 1;

  localparam int GAIN_FRAC_BITS_DEFAULT = 16;

  // APB register map
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;

  typedef enum logic [1:0] {
    REG_KP_GAIN        = 2'd0,
    REG_KI_GAIN        = 2'd1,
    REG_INTEGRAL_LIMIT = 2'd2,
    REG_MAX_OUTPUT     = 2'd3
  } reg_idx_t;

endpackage

>>> hw/rtl/pisc_in_if.sv
interface pisc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pisc_pkg::SPEED_W-1:0] measured_speed;
  logic signed [pisc_pkg::SPEED_W-1:0] target_speed;

  modport source (output valid, output measured_speed, output target_speed, input ready);
  modport sink   (input valid, input measured_speed, input target_speed, output ready);
endinterface

>>> hw/rtl/pisc_out_if.sv
interface pisc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pisc_pkg::SPEED_W-1:0] drive;
  logic                                integral_clamped;
  logic                                output_clamped;

  modport source (output valid, output drive, output integral_clamped, output output_clamped,
                  input ready);
  modport sink   (input valid, input drive, input integral_clamped, input output_clamped,
                  output ready);
endinterface

>>> hw/rtl/pi_speed_controller_clamped_core.sv
// Positional PI speed controller with symmetric integral and drive clamps.
//
// Channels: "sample" carries measured_speed and target_speed (signed rpm);
// "result" carries the drive value and the two clamp flags. Each channel is a
// valid/ready interface; a transfer happens on a rising edge with both high.
// Gains and limits are APB registers (kp_gain at 0x0, ki_gain at 0x4,
// integral_limit at 0x8, max_output at 0xC), which the user must write only
// while no sample is in flight; the block itself does not enforce this. Reads
// return the current register values, pready is always high.
//
// A sample passes the error, products, integral and output registers in turn.
// One sample is taken per cycle while the receiver does not stall. The
// integral update is a single add-and-clamp against its own register, which
// is what lets back-to-back samples chain through it.
//
// Reset (synchronous, active high) clears the gains, limits, the integral and
// every stage's valid bit. When the receiver stalls, the output register
// holds; each earlier stage keeps loading until it holds a waiting sample,
// then sample.ready drops. The integral only advances when a sample enters
// the integral stage, so stalls never repeat or skip an update.
module pi_speed_controller_clamped_core #(
  parameter int GAIN_FRAC_BITS = pisc_pkg::GAIN_FRAC_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  pisc_in_if.sink                      sample,
  pisc_out_if.source                   result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pisc_pkg::PADDR_W-1:0] paddr,
  input  logic [pisc_pkg::DATA_W-1:0]  pwdata,
  output logic [pisc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int SUM_W   = pisc_pkg::SUM_W;
  localparam int ACC_W   = pisc_pkg::ACC_W;
  localparam int PROD_W  = pisc_pkg::PROD_W;
  localparam int ERR_W   = pisc_pkg::ERR_W;
  localparam int SPEED_W = pisc_pkg::SPEED_W;
  localparam int GAIN_W  = pisc_pkg::GAIN_W;
  localparam int LIMIT_W = pisc_pkg::LIMIT_W;
  localparam int DATA_W  = pisc_pkg::DATA_W;

  // Largest value the 32-bit integral can hold, in the wide datapath
  localparam logic signed [SUM_W-1:0] AccMax = SUM_W'({1'b0, {(ACC_W-1){1'b1}}});

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0]  kp_gain;
  logic [GAIN_W-1:0]  ki_gain;
  logic [LIMIT_W-1:0] integral_limit;
  logic [LIMIT_W-1:0] max_output;
  logic               cfg_write;
  pisc_pkg::reg_idx_t cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = pisc_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain        <= '0;
      ki_gain        <= '0;
      integral_limit <= '0;
      max_output     <= '0;
    end else if (cfg_write) begin
      case (cfg_idx)
        pisc_pkg::REG_KP_GAIN:        kp_gain        <= pwdata[GAIN_W-1:0];
        pisc_pkg::REG_KI_GAIN:        ki_gain        <= pwdata[GAIN_W-1:0];
        pisc_pkg::REG_INTEGRAL_LIMIT: integral_limit <= pwdata[LIMIT_W-1:0];
        pisc_pkg::REG_MAX_OUTPUT:     max_output     <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      pisc_pkg::REG_KP_GAIN:        prdata = DATA_W'(kp_gain);
      pisc_pkg::REG_KI_GAIN:        prdata = DATA_W'(ki_gain);
      pisc_pkg::REG_INTEGRAL_LIMIT: prdata = DATA_W'(integral_limit);
      pisc_pkg::REG_MAX_OUTPUT:     prdata = DATA_W'(max_output);
      default:                      prdata = '0;
    endcase
  end

  // Clamp bounds in Q.F; the integral bound saturates to the accumulator range
  logic signed [SUM_W-1:0] ilim_wide;
  logic signed [SUM_W-1:0] ilim;
  logic signed [SUM_W-1:0] olim;

  assign ilim_wide = $signed(SUM_W'(integral_limit) << GAIN_FRAC_BITS);
  assign ilim      = (ilim_wide > AccMax) ? AccMax : ilim_wide;
  assign olim      = $signed(SUM_W'(max_output) << GAIN_FRAC_BITS);

  // ---------------------------------------------------------------------------
  // Pipeline control: each stage loads when empty or when the next one loads
  // ---------------------------------------------------------------------------
  logic v1, v2, v3, vo;
  logic en1, en2, en3, eno;

  assign eno = !vo || result.ready;
  assign en3 = !v3 || eno;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign sample.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (en1) v1 <= sample.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (eno) vo <= v3;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: error
  // ---------------------------------------------------------------------------
  logic signed [ERR_W-1:0] err;

  always_ff @(posedge clk) begin
    if (en1) begin
      err <= ERR_W'(sample.target_speed) - ERR_W'(sample.measured_speed);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: gain products
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] pterm;
  logic signed [PROD_W-1:0] iprod;

  always_ff @(posedge clk) begin
    if (en2) begin
      pterm <= $signed({1'b0, kp_gain}) * err;
      iprod <= $signed({1'b0, ki_gain}) * err;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: integral update and clamp
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0]  integral_acc;
  logic signed [SUM_W-1:0]  iterm_raw;
  logic signed [SUM_W-1:0]  iterm_next;
  logic                     ihit_next;
  logic signed [PROD_W-1:0] pterm_d;
  logic signed [ACC_W-1:0]  iterm;
  logic                     ihit;

  assign iterm_raw = SUM_W'(integral_acc) + SUM_W'(iprod);

  always_comb begin
    if (iterm_raw > ilim) begin
      iterm_next = ilim;
      ihit_next  = 1'b1;
    end else if (iterm_raw < -ilim) begin
      iterm_next = -ilim;
      ihit_next  = 1'b1;
    end else begin
      iterm_next = iterm_raw;
      ihit_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
    end else if (en3 && v2) begin
      integral_acc <= iterm_next[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      pterm_d <= pterm;
      iterm   <= iterm_next[ACC_W-1:0];
      ihit    <= ihit_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: P + I, drive clamp, floor shift to output units
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0]   sum_raw;
  logic signed [SUM_W-1:0]   sum_clamped;
  logic signed [SUM_W-1:0]   sum_shifted;
  logic                      ohit_next;
  logic signed [SPEED_W-1:0] drive;
  logic                      integral_clamped;
  logic                      output_clamped;

  assign sum_raw = SUM_W'(pterm_d) + SUM_W'(iterm);

  always_comb begin
    if (sum_raw > olim) begin
      sum_clamped = olim;
      ohit_next   = 1'b1;
    end else if (sum_raw < -olim) begin
      sum_clamped = -olim;
      ohit_next   = 1'b1;
    end else begin
      sum_clamped = sum_raw;
      ohit_next   = 1'b0;
    end
  end

  // Arithmetic shift floors toward minus infinity
  assign sum_shifted = sum_clamped >>> GAIN_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (eno) begin
      drive            <= sum_shifted[SPEED_W-1:0];
      integral_clamped <= ihit;
      output_clamped   <= ohit_next;
    end
  end

  assign result.valid            = vo;
  assign result.drive            = drive;
  assign result.integral_clamped = integral_clamped;
  assign result.output_clamped   = output_clamped;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // An empty output register must never block the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !vo |-> sample.ready)
    else $error("sample.ready low with empty output register");

  // The integral moves only when a sample enters the integral stage
  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    !(en3 && v2) |=> $stable(integral_acc))
    else $error("integral changed without a sample");

  // A sample in the integral stage carries an integral within its bound
  a_iterm_bound: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (SUM_W'(iterm) <= ilim && SUM_W'(iterm) >= -ilim))
    else $error("integral term outside its clamp");

  // The delivered drive never exceeds max_output
  a_drive_bound: assert property (@(posedge clk) disable iff (rst)
    vo |-> (SUM_W'(drive) <= $signed(SUM_W'(max_output)) &&
            SUM_W'(drive) >= -$signed(SUM_W'(max_output))))
    else $error("drive outside max_output");

  // A clamped drive sits exactly on the limit
  a_clamp_on_limit: assert property (@(posedge clk) disable iff (rst)
    (vo && output_clamped) |->
      (SUM_W'(drive) == SUM_W'(max_output) || SUM_W'(drive) == -SUM_W'(max_output)))
    else $error("output_clamped set but drive not at the limit");

endmodule

>>> test/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pisc_pkg::*;

  // Match the fraction width of the controller under test.
  localparam int FRAC = GAIN_FRAC_BITS_DEFAULT;
  // Saturation bound of the signed 32-bit integral register.
  localparam longint ACC_MAX = 64'sd2147483647;
  // Generous bound on the whole run, in clock cycles.
  localparam int unsigned CYCLE_LIMIT = 200_000;

  typedef logic signed [SPEED_W-1:0] speed_t;

  // One expected result: drive value plus the two clamp flags.
  typedef struct {
    logic signed [SPEED_W-1:0] drive;
    logic                      iclamp;
    logic                      oclamp;
  } drive_out_t;

  logic clk = 1'b0;
  logic rst;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  pisc_in_if  smp();
  pisc_out_if res();

  pi_speed_controller_clamped_core #(
    .GAIN_FRAC_BITS(FRAC)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp),
    .result (res),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #1 clk = ~clk;

  // Shadow copy of the controller: register file and integral.
  logic [GAIN_W-1:0]         kp_cfg = '0;
  logic [GAIN_W-1:0]         ki_cfg = '0;
  logic [LIMIT_W-1:0]        ilim_cfg = '0;
  logic [LIMIT_W-1:0]        omax_cfg = '0;
  logic signed [ACC_W-1:0]   integ_acc = '0;

  // Drive results predicted for accepted samples, oldest first.
  drive_out_t expected_drive_q[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Idling controls, owned by the test tasks.
  bit          src_idle_on = 1'b1;
  bit          sink_stall_on = 1'b1;
  // A long receiver hold-off is requested by bumping holdoff_req.
  int unsigned holdoff_req = 0;
  int unsigned holdoff_len = 0;

  // Compute the next drive from one sample and advance the shadow integral.
  function automatic drive_out_t predict_drive(speed_t measured, speed_t target);
    logic signed [ERR_W-1:0] err;
    longint                  pterm;
    longint                  iterm;
    longint                  sum;
    longint                  ilim;
    longint                  olim;
    longint                  shifted;
    drive_out_t              r;
    err   = {target[SPEED_W-1], target} - {measured[SPEED_W-1], measured};
    pterm = longint'(kp_cfg) * longint'(err);
    ilim  = longint'(ilim_cfg) <<< FRAC;
    olim  = longint'(omax_cfg) <<< FRAC;
    // Keep the integral bound inside the 32-bit integral register.
    if (ilim > ACC_MAX) ilim = ACC_MAX;

    iterm    = longint'(integ_acc) + longint'(ki_cfg) * longint'(err);
    r.iclamp = (iterm > ilim) || (iterm < -ilim);
    if (iterm > ilim) iterm = ilim;
    else if (iterm < -ilim) iterm = -ilim;
    integ_acc = iterm[ACC_W-1:0];

    sum      = pterm + iterm;
    r.oclamp = (sum > olim) || (sum < -olim);
    if (sum > olim) sum = olim;
    else if (sum < -olim) sum = -olim;

    // Arithmetic shift floors toward minus infinity.
    shifted = sum >>> FRAC;
    r.drive = shifted[SPEED_W-1:0];
    return r;
  endfunction

  // Offer one sample, idle at random first, and predict it once transferred.
  task automatic send_sample(input speed_t measured, input speed_t target);
    while (src_idle_on && $urandom_range(99) < 26) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid          <= 1'b1;
    smp.measured_speed <= measured;
    smp.target_speed   <= target;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    expected_drive_q.push_back(predict_drive(measured, target));
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic wait_drained();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (expected_drive_q.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, then the bus is left idle.
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_KP_GAIN:        kp_cfg = val;
      REG_KI_GAIN:        ki_cfg = val;
      REG_INTEGRAL_LIMIT: ilim_cfg = val[LIMIT_W-1:0];
      REG_MAX_OUTPUT:     omax_cfg = val[LIMIT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
                           input logic [DATA_W-1:0] ilim, input logic [DATA_W-1:0] omax);
    wait_drained();
    write_reg(REG_KP_GAIN, kp);
    write_reg(REG_KI_GAIN, ki);
    write_reg(REG_INTEGRAL_LIMIT, ilim);
    write_reg(REG_MAX_OUTPUT, omax);
  endtask

  // Mix of full-range speeds, extremes and a target close to the measurement.
  function automatic void pick_speeds(output speed_t measured, output speed_t target);
    speed_t corners[5] = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFF};
    case ($urandom_range(9))
      0: begin
        measured = corners[$urandom_range(4)];
        target   = corners[$urandom_range(4)];
      end
      1, 2, 3, 4: begin
        measured = speed_t'($urandom);
        target   = speed_t'($urandom);
      end
      default: begin
        measured = speed_t'($urandom);
        target   = measured + speed_t'($urandom_range(600)) - speed_t'(300);
      end
    endcase
  endfunction

  // With all registers at reset the drive is zero whatever the speeds.
  task automatic test_reset_defaults();
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh8000);
    wait_drained();
  endtask

  // Unity proportional gain: full error swing, and errors right at the clamp.
  task automatic test_field_extremes();
    write_all(32'h0001_0000, 32'h0, 32'h0, 32'd32767);
    send_sample(16'sh8000, 16'sh7FFF);   // +65535, clamps high
    send_sample(16'sh7FFF, 16'sh8000);   // -65535, clamps low
    send_sample(16'sd1234, 16'sd1234);   // zero error
    send_sample(16'sd0, 16'sh7FFF);      // exactly at +limit, no flag
    send_sample(16'sh7FFF, 16'sd0);      // exactly at -limit, no flag
    send_sample(16'sd0, 16'sh8000);      // one past -limit
    wait_drained();
  endtask

  // Walk the integral onto its bound and one step past, on each side in turn.
  task automatic test_integral_clamp();
    write_all(32'h0, 32'h0001_0000, 32'd100, 32'd32767);
    send_sample(16'sd0, 16'sd100);
    send_sample(16'sd0, 16'sd1);
    send_sample(16'sd200, 16'sd0);
    send_sample(16'sd1, 16'sd0);
    wait_drained();
  endtask

  // Zero limits pin the integral and drive to zero; flags track nonzero sums.
  task automatic test_zero_limits();
    write_all(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
    send_sample(16'sd0, 16'sd5);
    send_sample(16'sd9, 16'sd9);
    send_sample(16'sd7, 16'sd0);
    wait_drained();
  endtask

  // Build up the integral, then lower its limit: the next step clamps it.
  task automatic test_limit_lowered();
    write_all(32'h0, 32'h0001_0000, 32'd1000, 32'd32767);
    send_sample(16'sd0, 16'sd1000);
    wait_drained();
    write_reg(REG_INTEGRAL_LIMIT, 32'd10);
    send_sample(16'sd42, 16'sd42);
    wait_drained();
  endtask

  // Fractional gain floors negative values; full-scale gains; masked limit write.
  task automatic test_gain_extremes();
    write_all(32'h0000_8000, 32'h0, 32'd32767, 32'd32767);
    send_sample(16'sd1, 16'sd0);
    send_sample(16'sd0, 16'sd1);
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd32767);
    send_sample(16'sd0, 16'sd3);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sd0, 16'sd0);
    wait_drained();
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall input,
  // then the sender pauses until everything has drained before resuming.
  task automatic test_backpressure();
    speed_t m;
    speed_t t;
    write_all(32'h0002_0000, 32'h0000_0400, 32'd20000, 32'd30000);
    src_idle_on   = 1'b0;
    holdoff_len   = 300;
    holdoff_req   = holdoff_req + 1;
    for (int n = 0; n < 48; n++) begin
      pick_speeds(m, t);
      send_sample(m, t);
    end
    wait_drained();
    src_idle_on = 1'b1;
    for (int n = 0; n < 24; n++) begin
      pick_speeds(m, t);
      send_sample(m, t);
    end
    wait_drained();
  endtask

  // Random register settings per phase, random speeds within each phase.
  task automatic test_random_loop();
    speed_t            m;
    speed_t            t;
    logic [DATA_W-1:0] kp;
    logic [DATA_W-1:0] ki;
    logic [DATA_W-1:0] ilim;
    logic [DATA_W-1:0] omax;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(3))
        0:       kp = 32'h0;
        1:       kp = 32'hFFFF_FFFF;
        default: kp = $urandom_range(32'h0004_0000);
      endcase
      case ($urandom_range(3))
        0:       ki = 32'h0;
        1:       ki = $urandom;
        default: ki = $urandom_range(32'h0000_2000);
      endcase
      case ($urandom_range(3))
        0:       ilim = 32'h0;
        1:       ilim = 32'd32767;
        default: ilim = $urandom_range(32767);
      endcase
      case ($urandom_range(3))
        0:       omax = 32'h0;
        1:       omax = 32'd32767;
        default: omax = $urandom_range(32767);
      endcase
      // Phase 1 always runs at the top of every register's range.
      if (phase == 1) begin
        kp   = 32'hFFFF_FFFF;
        ki   = 32'hFFFF_FFFF;
        ilim = 32'd32767;
        omax = 32'd32767;
      end
      write_all(kp, ki, ilim, omax);
      // Phase 2 is a long stretch with no idling on either side.
      src_idle_on   = (phase != 2);
      sink_stall_on = (phase != 2);
      for (int n = 0; n < 100; n++) begin
        pick_speeds(m, t);
        send_sample(m, t);
      end
    end
    wait_drained();
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
  endtask

  // Result receiver: check each transfer, then choose ready for the next cycle.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned holdoff_seen;
    drive_out_t  want;
    stall_left   = 0;
    holdoff_seen = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res.valid && res.ready) begin
        if (expected_drive_q.size() == 0) begin
          $display("%0t: drive=%0d with no sample outstanding", $time, res.drive);
          mismatch_count++;
        end else begin
          want = expected_drive_q.pop_front();
          if (res.drive !== want.drive) begin
            $display("%0t: drive expected %0d actual %0d", $time, want.drive, res.drive);
            mismatch_count++;
          end
          if (res.integral_clamped !== want.iclamp) begin
            $display("%0t: integral_clamped expected %0b actual %0b",
                     $time, want.iclamp, res.integral_clamped);
            mismatch_count++;
          end
          if (res.output_clamped !== want.oclamp) begin
            $display("%0t: output_clamped expected %0b actual %0b",
                     $time, want.oclamp, res.output_clamped);
            mismatch_count++;
          end
        end
      end
      // Pick up a new hold-off request and count it down here.
      if (holdoff_seen != holdoff_req) begin
        holdoff_seen = holdoff_req;
        stall_left   = holdoff_len;
      end
      if (stall_left != 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= !sink_stall_on || ($urandom_range(99) >= 26);
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : run_tests
    // Drive every input to a known value before the first edge.
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    smp.valid          <= 1'b0;
    smp.measured_speed <= '0;
    smp.target_speed   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_field_extremes();
    test_integral_clamp();
    test_zero_limits();
    test_limit_lowered();
    test_gain_extremes();
    test_backpressure();
    test_random_loop();

    // Let any stray result surface before the verdict.
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
